[hdl/rbsd_pkg.sv]
// Package for the repetition BPSK soft decoder: widths, register indexes,
// reset values, shared types and the bits-per-word clamp function.
// No dependencies.
package rbsd_pkg;

   localparam int MAX_BITS    = 14;
   localparam int BPW_W       = 4;
   localparam int SAMPLE_W    = 16;
   localparam int ACC_W       = 25;
   localparam int MAG_W       = 24;
   localparam int THR_W       = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int PAIR_N      = (MAX_BITS + 1) / 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BITS_PER_WORD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_THRESHOLD = 2'd1;

   localparam logic [BPW_W-1:0] BPW_RESET = 4'd1;
   localparam logic [BPW_W-1:0] BPW_MAX   = BPW_W'(MAX_BITS);
   localparam logic [THR_W-1:0] THRESH_RESET = 24'd20480;

   // Largest accumulator magnitude; also the "no candidate" value of the minimum.
   localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef acc_type acc_array_type [MAX_BITS];
   typedef logic [MAG_W-1:0] mag_type;

   // Control that travels with a finished accumulator snapshot.
   typedef struct packed {
      logic [BPW_W-1:0] nbits;
      logic [THR_W-1:0] threshold;
   } snap_ctrl_type;

   // Zero acts as one, anything above the lane count acts as the lane count.
   function automatic logic [BPW_W-1:0] effective_bits(input logic [BPW_W-1:0] raw);
      logic [BPW_W-1:0] res;
      if (raw == '0) begin
         res = BPW_W'(1);
      end else if (raw > BPW_MAX) begin
         res = BPW_MAX;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

[hdl/rbsd_reduce.sv]
// Result pipeline of the repetition BPSK soft decoder: hard decisions,
// minimum magnitude and threshold compare over a snapshot of the accumulators.
// Depends on rbsd_pkg.
module rbsd_reduce
   import rbsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                snap_valid,
   output logic                snap_ready,
   input  acc_array_type       snap_acc,
   input  snap_ctrl_type       snap_ctrl,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [MAX_BITS-1:0] rsp_decoded_word,
   output logic [MAG_W-1:0]    rsp_reliability,
   output logic                rsp_low_reliability
);

   // Stage two: signs, magnitudes and the first level of the minimum tree.
   logic                valid2_ff, valid2_in;
   logic [MAX_BITS-1:0] word2_ff, word2_in;
   mag_type             pair2_ff [PAIR_N];
   mag_type             pair2_in [PAIR_N];
   logic [THR_W-1:0]    thr2_ff;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MAX_BITS-1:0] word3_ff;
   mag_type             rel3_ff, rel3_in;
   logic                low3_ff, low3_in;

   logic    load2, load3;
   mag_type mag [MAX_BITS];

   assign load3      = valid2_ff && (!rsp_valid_ff || rsp_ready);
   assign snap_ready = !valid2_ff || load3;
   assign load2      = snap_valid && snap_ready;

   always_comb begin
      logic [ACC_W-1:0] t;
      word2_in = '0;
      for (int j = 0; j < MAX_BITS; j++) begin
         t = snap_acc[j][ACC_W-1] ? (~snap_acc[j] + ACC_W'(1)) : snap_acc[j];
         if (BPW_W'(j) < snap_ctrl.nbits) begin
            word2_in[j] = snap_acc[j][ACC_W-1];
            mag[j]      = t[MAG_W-1:0];
         end else begin
            mag[j]      = MAG_LIMIT;
         end
      end
      for (int k = 0; k < PAIR_N; k++) begin
         if (2 * k + 1 < MAX_BITS) begin
            pair2_in[k] = (mag[2*k+1] < mag[2*k]) ? mag[2*k+1] : mag[2*k];
         end else begin
            pair2_in[k] = mag[2*k];
         end
      end
   end

   always_comb begin
      rel3_in = pair2_ff[0];
      for (int k = 1; k < PAIR_N; k++) begin
         if (pair2_ff[k] < rel3_in) begin
            rel3_in = pair2_ff[k];
         end
      end
      low3_in = (rel3_in <= thr2_ff);
   end

   assign valid2_in    = load2 ? 1'b1 : (load3 ? 1'b0 : valid2_ff);
   assign rsp_valid_in = load3 ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid2_ff    <= valid2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         word2_ff <= word2_in;
         pair2_ff <= pair2_in;
         thr2_ff  <= snap_ctrl.threshold;
      end
      if (load3) begin
         word3_ff <= word2_ff;
         rel3_ff  <= rel3_in;
         low3_ff  <= low3_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_decoded_word    = word3_ff;
   assign rsp_reliability     = rel3_ff;
   assign rsp_low_reliability = low3_ff;

   // A result waiting at the output must not be replaced by a new one.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rel3_ff)
                                        && $stable(word3_ff)))
      else $error("rbsd_reduce: pending result was overwritten");

   // The flag always agrees with the reliability and the captured threshold.
   a_flag_consistent: assert property (@(posedge clock) disable iff (reset)
      load3 |=> (low3_ff == (rel3_ff <= $past(thr2_ff))))
      else $error("rbsd_reduce: low-reliability flag disagrees with reliability");

   // Stage two holds its contents while the output is blocked.
   a_stage2_held: assert property (@(posedge clock) disable iff (reset)
      (valid2_ff && !load3) |=> (valid2_ff && $stable(word2_ff)))
      else $error("rbsd_reduce: stage two lost an item");

endmodule

[hdl/repetition_bpsk_soft_decoder_unit.sv]
// Top level of the repetition BPSK soft decoder: configuration registers,
// per-bit soft accumulators and the snapshot stage. Depends on rbsd_pkg and
// instantiates rbsd_reduce.
//
// Throughput: one request per clock cycle, sustained, with rsp_ready high.
// Path: the request ending the vector loads the snapshot register at the edge
// that accepts it; the result then passes the minimum tree register and the
// output register, where it is held until it is taken with rsp_ready.
// Reset: synchronous, active high; clears accumulators, bit position, pipeline
// valids, and returns bits_per_word to 1 and error_threshold to 20480 (10.0).
module repetition_bpsk_soft_decoder_unit
   import rbsd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Request channel: one subcarrier per request.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_real,
   input  logic                       req_carrier_used,
   input  logic                       req_whitener_bit,
   input  logic                       req_last_in_vector,
   // Result channel: one word per vector.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [MAX_BITS-1:0]        rsp_decoded_word,
   output logic [MAG_W-1:0]           rsp_reliability,
   output logic                       rsp_low_reliability,
   // Register write channel.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   // Saturation bounds on the widened sum of accumulator and sample.
   localparam int SUM_W = ACC_W + 1;
   localparam logic signed [SUM_W-1:0] SUM_POS_LIMIT = SUM_W'(MAG_LIMIT);
   localparam logic signed [SUM_W-1:0] SUM_NEG_LIMIT = -SUM_POS_LIMIT;

   // Configuration registers.
   logic [BPW_W-1:0] bpw_ff, bpw_in;
   logic [THR_W-1:0] thr_ff, thr_in;

   // Live accumulators and the lane that the next used carrier goes into.
   acc_array_type    acc_ff, acc_in, acc_upd;
   logic [BPW_W-1:0] pos_ff, pos_in;

   // Snapshot of the accumulators taken when a vector ends.
   logic             snap_valid_ff, snap_valid_in;
   acc_array_type    snap_acc_ff;
   snap_ctrl_type    snap_ctrl_ff, snap_ctrl_in;
   logic             snap_ready;

   logic                    req_fire, csr_fire, snap_load;
   logic [BPW_W-1:0]        nbits, pos_sel, pos_inc, pos_next;
   acc_type                 acc_rd, acc_sat;
   logic signed [SAMPLE_W:0] soft_val;
   logic signed [SUM_W-1:0] sum;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      bpw_in = bpw_ff;
      thr_in = thr_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_BITS_PER_WORD:   bpw_in = csr_wdata[BPW_W-1:0];
            CSR_ERROR_THRESHOLD: thr_in = csr_wdata[THR_W-1:0];
            default:             ;
         endcase
      end
   end

   // A request can always enter unless a finished snapshot is still stuck
   // waiting for the result pipeline.
   assign req_ready = !snap_valid_ff || snap_ready;
   assign req_fire  = req_valid && req_ready;
   assign snap_load = req_fire && req_last_in_vector;

   // The accumulate path: pick the lane, undo whitening, add with saturation.
   assign nbits   = effective_bits(bpw_ff);
   // If bits_per_word was lowered mid-vector, the position restarts at lane 0.
   assign pos_sel = (pos_ff >= nbits) ? '0 : pos_ff;
   assign acc_rd  = acc_ff[pos_sel];

   // The sample is widened by one bit so that negating the most negative
   // value is exact.
   always_comb begin
      soft_val = {req_sample_real[SAMPLE_W-1], req_sample_real};
      if (req_whitener_bit) begin
         soft_val = -soft_val;
      end
   end

   assign sum = {acc_rd[ACC_W-1], acc_rd}
              + {{(SUM_W - SAMPLE_W - 1){soft_val[SAMPLE_W]}}, soft_val};

   always_comb begin
      if (sum > SUM_POS_LIMIT) begin
         acc_sat = ACC_W'(SUM_POS_LIMIT);
      end else if (sum < SUM_NEG_LIMIT) begin
         acc_sat = ACC_W'(SUM_NEG_LIMIT);
      end else begin
         acc_sat = sum[ACC_W-1:0];
      end
   end

   // Lanes advance cyclically over the active bits of the word.
   assign pos_inc  = pos_sel + BPW_W'(1);
   assign pos_next = (pos_inc >= nbits) ? '0 : pos_inc;

   always_comb begin
      for (int j = 0; j < MAX_BITS; j++) begin
         if (req_carrier_used && (pos_sel == BPW_W'(j))) begin
            acc_upd[j] = acc_sat;
         end else begin
            acc_upd[j] = acc_ff[j];
         end
      end
   end

   // The last carrier of a vector is folded in first, the totals move to the
   // snapshot, and the live accumulators start over from zero.
   always_comb begin
      acc_in = acc_ff;
      pos_in = pos_ff;
      if (req_fire) begin
         if (req_last_in_vector) begin
            for (int j = 0; j < MAX_BITS; j++) begin
               acc_in[j] = '0;
            end
            pos_in = '0;
         end else begin
            acc_in = acc_upd;
            if (req_carrier_used) begin
               pos_in = pos_next;
            end
         end
      end
   end

   assign snap_ctrl_in.nbits     = nbits;
   assign snap_ctrl_in.threshold = thr_ff;
   assign snap_valid_in = snap_load ? 1'b1 : (snap_ready ? 1'b0 : snap_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         bpw_ff        <= BPW_RESET;
         thr_ff        <= THRESH_RESET;
         pos_ff        <= '0;
         snap_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_BITS; j++) begin
            acc_ff[j] <= '0;
         end
      end else begin
         bpw_ff        <= bpw_in;
         thr_ff        <= thr_in;
         pos_ff        <= pos_in;
         snap_valid_ff <= snap_valid_in;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_acc_ff  <= acc_upd;
         snap_ctrl_ff <= snap_ctrl_in;
      end
   end

   // Decisions, minimum magnitude and threshold compare.
   rbsd_reduce u_reduce (
      .clock               (clock),
      .reset               (reset),
      .snap_valid          (snap_valid_ff),
      .snap_ready          (snap_ready),
      .snap_acc            (snap_acc_ff),
      .snap_ctrl           (snap_ctrl_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_decoded_word    (rsp_decoded_word),
      .rsp_reliability     (rsp_reliability),
      .rsp_low_reliability (rsp_low_reliability)
   );

   // The accumulators stay within the saturation bounds.
   function automatic logic acc_in_range(input acc_array_type a);
      logic ok;
      ok = 1'b1;
      for (int j = 0; j < MAX_BITS; j++) begin
         if (($signed({a[j][ACC_W-1], a[j]}) > SUM_POS_LIMIT)
             || ($signed({a[j][ACC_W-1], a[j]}) < SUM_NEG_LIMIT)) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic acc_all_zero(input acc_array_type a);
      logic z;
      z = 1'b1;
      for (int j = 0; j < MAX_BITS; j++) begin
         if (a[j] != '0) begin
            z = 1'b0;
         end
      end
      return z;
   endfunction

   // The position always names an existing lane.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < BPW_MAX)
      else $error("bit position points past the last lane");

   // Ending a vector clears every accumulator and the position.
   a_vector_clears: assert property (@(posedge clock) disable iff (reset)
      snap_load |=> (acc_all_zero(acc_ff) && (pos_ff == '0)))
      else $error("accumulators not cleared after the end of a vector");

   // Saturation keeps the magnitudes within the reliability field.
   a_acc_bounded: assert property (@(posedge clock) disable iff (reset)
      acc_in_range(acc_ff))
      else $error("accumulator outside the saturation bounds");

   // A snapshot is never overwritten while the result pipeline is blocked.
   a_snap_held: assert property (@(posedge clock) disable iff (reset)
      (snap_valid_ff && !snap_ready) |=> (snap_valid_ff && $stable(snap_ctrl_ff)))
      else $error("snapshot overwritten before it was taken");

endmodule
